// ===== rtl/scs_pkg.sv =====
package scs_pkg;

  // Field widths
  localparam int unsigned ANGLE_W   = 9;
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned CYCLE_W   = 8;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned DIST_W    = 14;
  localparam int unsigned MS_W      = 14;
  localparam int unsigned STRENGTH_W = 7;
  localparam int unsigned NEAR_W    = 13;
  localparam int unsigned DEPTH_W   = 8;
  localparam int unsigned PADDR_W   = 5;
  localparam int unsigned PDATA_W   = 32;

  // Default phase lengths in ms
  localparam int unsigned PREP_MS_DEF    = 300;
  localparam int unsigned RELEASE_MS_DEF = 500;
  localparam int unsigned FINISH_MS_DEF  = 1000;

  localparam logic [ANGLE_W-1:0] ANGLE_OPEN = 9'd270;

  // Register reset values
  localparam logic [STRENGTH_W-1:0] STRENGTH_RST = 7'd90;
  localparam logic [CYCLE_W-1:0]    CYCLES_RST   = 8'd3;
  localparam logic [MS_W-1:0]       REACH_RST    = 14'd500;
  localparam logic [MS_W-1:0]       HOLD_RST     = 14'd500;
  localparam logic [NEAR_W-1:0]     NEAR_RST     = 13'd100;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK   = 2'd0,
    REQ_START  = 2'd1,
    REQ_STOP   = 2'd2,
    REQ_SAMPLE = 2'd3
  } req_e;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE    = 3'd0,
    PH_PREPARE = 3'd1,
    PH_SQUEEZE = 3'd2,
    PH_HOLD    = 3'd3,
    PH_RELEASE = 3'd4,
    PH_WAIT    = 3'd5,
    PH_FINISH  = 3'd6
  } phase_e;

  // Configuration register index (byte address / 4)
  typedef enum logic [2:0] {
    REG_STRENGTH = 3'd0,
    REG_CYCLES   = 3'd1,
    REG_REACH    = 3'd2,
    REG_HOLD     = 3'd3,
    REG_SENSOR   = 3'd4,
    REG_NEAR     = 3'd5
  } reg_e;

  typedef enum logic [0:0] {
    SEQ_READY = 1'b0,
    SEQ_RAMP  = 1'b1
  } seq_e;

  typedef enum logic [1:0] {
    RAMP_IDLE = 2'd0,
    RAMP_MUL  = 2'd1,
    RAMP_NORM = 2'd2,
    RAMP_DIV  = 2'd3
  } ramp_e;

  // Ramp unit request and response
  typedef struct packed {
    logic               start;
    logic [DEPTH_W-1:0] depth;
    logic [MS_W-1:0]    elapsed;
    logic [MS_W-1:0]    reach;
  } ramp_req_t;

  typedef struct packed {
    logic               done;
    logic [DEPTH_W-1:0] quot;
  } ramp_rsp_t;

  // floor(min(s,100)*180/100) = floor(s*1845/1024) for s <= 100
  function automatic logic [DEPTH_W-1:0] depth_f(logic [STRENGTH_W-1:0] s);
    logic [STRENGTH_W-1:0] sc;
    logic [17:0]           prod;
    sc   = (s > 7'd100) ? 7'd100 : s;
    prod = 18'(sc) * 18'd1845;
    return prod[17:10];
  endfunction

endpackage

// ===== rtl/scs_req_if.sv =====
interface scs_req_if;
  logic                         valid;
  logic                         ready;
  logic [scs_pkg::REQ_W-1:0]    req_type;
  logic [scs_pkg::DIST_W-1:0]   distance_mm;

  modport source (output valid, input ready, output req_type, output distance_mm);
  modport sink   (input valid, output ready, input req_type, input distance_mm);
endinterface

// ===== rtl/scs_res_if.sv =====
interface scs_res_if;
  logic                          valid;
  logic                          ready;
  logic [scs_pkg::ANGLE_W-1:0]   servo_angle;
  logic [scs_pkg::PHASE_W-1:0]   phase_code;
  logic [scs_pkg::CYCLE_W-1:0]   cycles_done;
  logic                          run_done;

  modport source (output valid, input ready, output servo_angle, output phase_code,
                  output cycles_done, output run_done);
  modport sink   (input valid, output ready, input servo_angle, input phase_code,
                  input cycles_done, input run_done);
endinterface

// ===== rtl/scs_ramp.sv =====
// Bit-serial ramp step: quot = ceil(depth * elapsed / reach).
// Eight multiply steps (one multiplier bit each), one rounding step,
// eight restoring divide steps (one quotient bit each).
module scs_ramp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scs_pkg::ramp_req_t  req_i,
  output scs_pkg::ramp_rsp_t  rsp_o
);
  import scs_pkg::*;

  localparam int unsigned ACC_W = DEPTH_W + MS_W;

  ramp_e               state_q, state_d;
  logic [2:0]          cnt_q, cnt_d;
  logic                done_q, done_d;
  logic [DEPTH_W-1:0]  mult_q, mult_d;
  logic [MS_W-1:0]     mcand_q, mcand_d;
  logic [MS_W-1:0]     reach_q, reach_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [MS_W-1:0]     rem_q, rem_d;
  logic [DEPTH_W-1:0]  lo_q, lo_d;
  logic [DEPTH_W-1:0]  quot_q, quot_d;

  logic [ACC_W:0]      num;
  logic [MS_W:0]       trial;
  logic [MS_W:0]       diff;
  logic                ge;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RAMP_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    mult_q  <= mult_d;
    mcand_q <= mcand_d;
    reach_q <= reach_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    lo_q    <= lo_d;
    quot_q  <= quot_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    mult_d  = mult_q;
    mcand_d = mcand_q;
    reach_d = reach_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    lo_d    = lo_q;
    quot_d  = quot_q;

    // numerator for the ceiling: product + reach - 1
    num   = {1'b0, acc_q} + (ACC_W+1)'(reach_q) - (ACC_W+1)'(1);
    trial = {rem_q, lo_q[DEPTH_W-1]};
    diff  = trial - {1'b0, reach_q};
    ge    = (trial >= {1'b0, reach_q});

    case (state_q)
      RAMP_IDLE: begin
        if (req_i.start) begin
          mult_d  = req_i.depth;
          mcand_d = req_i.elapsed;
          reach_d = req_i.reach;
          acc_d   = '0;
          cnt_d   = '0;
          state_d = RAMP_MUL;
        end
      end
      RAMP_MUL: begin
        // MSB-first shift-add
        acc_d  = {acc_q[ACC_W-2:0], 1'b0}
               + (mult_q[DEPTH_W-1] ? ACC_W'(mcand_q) : '0);
        mult_d = {mult_q[DEPTH_W-2:0], 1'b0};
        cnt_d  = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          state_d = RAMP_NORM;
        end
      end
      RAMP_NORM: begin
        // quotient fits 8 bits, so the upper numerator bits are below reach
        rem_d   = num[ACC_W-1:DEPTH_W];
        lo_d    = num[DEPTH_W-1:0];
        quot_d  = '0;
        cnt_d   = '0;
        state_d = RAMP_DIV;
      end
      RAMP_DIV: begin
        rem_d  = ge ? diff[MS_W-1:0] : trial[MS_W-1:0];
        lo_d   = {lo_q[DEPTH_W-2:0], 1'b0};
        quot_d = {quot_q[DEPTH_W-2:0], ge};
        cnt_d  = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          done_d  = 1'b1;
          state_d = RAMP_IDLE;
        end
      end
      default: state_d = RAMP_IDLE;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

  // Partial remainder stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == RAMP_DIV) |-> (rem_q < reach_q))
    else $error("ramp remainder not below divisor");

  // A new request only arrives while the unit is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> (state_q == RAMP_IDLE))
    else $error("ramp started while busy");

  // Quotient never exceeds the larger of the multiplier operand and 180
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> (quot_q <= $past(mult_q, 17) || quot_q <= 8'd180))
    else $error("ramp quotient out of range");

endmodule

// ===== rtl/squeeze_cycle_sequencer.sv =====
// Channel   Dir  Fields                                           Handshake
// req_if    in   req_type, distance_mm                            valid/ready
// res_if    out  servo_angle, phase_code, cycles_done, run_done   valid/ready
// apb       in   psel/penable/pwrite/paddr/pwdata -> prdata       pready tied high
//
// Most requests update the state at the accepting edge; the result then
// enters the output register once it is free, and the next request is
// taken only after that.
// A squeeze tick that is not the last of the ramp runs the bit-serial ramp
// unit: 8 multiply + 1 round + 8 divide steps before the next request is taken.
// Reset (rst_ni low, asynchronous) gives idle, angle 270, default registers.
// The output register holds a result while res_if.ready is low; one more
// finished result may wait behind it, after which req_if.ready drops.
module squeeze_cycle_sequencer #(
  parameter int unsigned PREP_MS    = scs_pkg::PREP_MS_DEF,
  parameter int unsigned RELEASE_MS = scs_pkg::RELEASE_MS_DEF,
  parameter int unsigned FINISH_MS  = scs_pkg::FINISH_MS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  scs_req_if.sink                       req_if,
  scs_res_if.source                     res_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [scs_pkg::PADDR_W-1:0]   paddr,
  input  logic [scs_pkg::PDATA_W-1:0]   pwdata,
  output logic [scs_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import scs_pkg::*;

  // Configuration registers
  logic [STRENGTH_W-1:0] strength_q;
  logic [CYCLE_W-1:0]    target_q;
  logic [MS_W-1:0]       reach_q;
  logic [MS_W-1:0]       hold_q;
  logic                  sensor_q;
  logic [NEAR_W-1:0]     near_q;

  // Sequencer state
  seq_e                  seq_q, seq_d;
  phase_e                phase_q, phase_d;
  logic [MS_W-1:0]       elapsed_q, elapsed_d;
  logic [CYCLE_W-1:0]    cyc_q, cyc_d;
  logic [1:0]            hits_q, hits_d;
  logic [ANGLE_W-1:0]    angle_q, angle_d;
  logic                  pend_q, pend_d;
  logic                  done_q, done_d;

  // Output register
  logic                  res_valid_q;
  logic [ANGLE_W-1:0]    res_angle_q;
  logic [PHASE_W-1:0]    res_phase_q;
  logic [CYCLE_W-1:0]    res_cyc_q;
  logic                  res_done_q;

  logic                  accept;
  logic                  res_load;
  logic                  cfg_wr;
  reg_e                  cfg_sel;
  logic [MS_W-1:0]       el_inc;
  logic [DEPTH_W-1:0]    depth;
  logic [1:0]            hits_inc;
  ramp_req_t             ramp_req;
  ramp_rsp_t             ramp_rsp;

  // APB register file
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q <= STRENGTH_RST;
      target_q   <= CYCLES_RST;
      reach_q    <= REACH_RST;
      hold_q     <= HOLD_RST;
      sensor_q   <= 1'b0;
      near_q     <= NEAR_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_STRENGTH: strength_q <= pwdata[STRENGTH_W-1:0];
        REG_CYCLES:   target_q   <= pwdata[CYCLE_W-1:0];
        REG_REACH:    reach_q    <= pwdata[MS_W-1:0];
        REG_HOLD:     hold_q     <= pwdata[MS_W-1:0];
        REG_SENSOR:   sensor_q   <= pwdata[0];
        REG_NEAR:     near_q     <= pwdata[NEAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_STRENGTH: prdata = PDATA_W'(strength_q);
      REG_CYCLES:   prdata = PDATA_W'(target_q);
      REG_REACH:    prdata = PDATA_W'(reach_q);
      REG_HOLD:     prdata = PDATA_W'(hold_q);
      REG_SENSOR:   prdata = PDATA_W'(sensor_q);
      REG_NEAR:     prdata = PDATA_W'(near_q);
      default:      prdata = '0;
    endcase
  end

  // Ramp unit
  scs_ramp u_ramp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ramp_req),
    .rsp_o  (ramp_rsp)
  );

  assign depth    = depth_f(strength_q);
  assign el_inc   = (elapsed_q == '1) ? elapsed_q : elapsed_q + MS_W'(1);
  assign hits_inc = hits_q + 2'd1;

  assign req_if.ready = (seq_q == SEQ_READY) && !pend_q;
  assign accept       = req_if.valid && req_if.ready;
  assign res_load     = pend_q && (!res_valid_q || res_if.ready);

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q     <= SEQ_READY;
      phase_q   <= PH_IDLE;
      elapsed_q <= '0;
      cyc_q     <= '0;
      hits_q    <= '0;
      angle_q   <= ANGLE_OPEN;
      pend_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      seq_q     <= seq_d;
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      cyc_q     <= cyc_d;
      hits_q    <= hits_d;
      angle_q   <= angle_d;
      pend_q    <= pend_d;
      done_q    <= done_d;
    end
  end

  // Request handling and phase sequencing
  always_comb begin
    seq_d     = seq_q;
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    cyc_d     = cyc_q;
    hits_d    = hits_q;
    angle_d   = angle_q;
    pend_d    = pend_q;
    done_d    = done_q;

    ramp_req.start   = 1'b0;
    ramp_req.depth   = depth;
    ramp_req.elapsed = el_inc;
    ramp_req.reach   = reach_q;

    if (res_load) begin
      pend_d = 1'b0;
    end

    // Ramp finished: angle = 270 - ceil(d*elapsed/reach)
    if (seq_q == SEQ_RAMP && ramp_rsp.done) begin
      angle_d = ANGLE_OPEN - ANGLE_W'(ramp_rsp.quot);
      pend_d  = 1'b1;
      seq_d   = SEQ_READY;
    end

    if (accept) begin
      pend_d = 1'b1;
      done_d = 1'b0;
      case (req_e'(req_if.req_type))
        REQ_TICK: begin
          if (phase_q != PH_IDLE) begin
            elapsed_d = el_inc;
            case (phase_q)
              PH_PREPARE: begin
                angle_d = ANGLE_OPEN;
                if (el_inc > MS_W'(PREP_MS)) begin
                  phase_d   = PH_SQUEEZE;
                  elapsed_d = '0;
                end
              end
              PH_SQUEEZE: begin
                if (el_inc >= reach_q) begin
                  angle_d   = ANGLE_OPEN - ANGLE_W'(depth);
                  phase_d   = PH_HOLD;
                  elapsed_d = '0;
                end else begin
                  ramp_req.start = 1'b1;
                  seq_d          = SEQ_RAMP;
                  pend_d         = 1'b0;
                end
              end
              PH_HOLD: begin
                if (el_inc >= hold_q) begin
                  if (cyc_q != '1) begin
                    cyc_d = cyc_q + CYCLE_W'(1);
                  end
                  phase_d   = PH_RELEASE;
                  elapsed_d = '0;
                end
              end
              PH_RELEASE: begin
                angle_d = ANGLE_OPEN;
                if (el_inc >= MS_W'(RELEASE_MS)) begin
                  elapsed_d = '0;
                  if (cyc_q >= target_q) begin
                    phase_d = PH_FINISH;
                    done_d  = 1'b1;
                  end else begin
                    phase_d = PH_WAIT;
                  end
                end
              end
              PH_WAIT: begin
                phase_d   = PH_SQUEEZE;
                elapsed_d = '0;
              end
              PH_FINISH: begin
                if (el_inc >= MS_W'(FINISH_MS)) begin
                  angle_d   = ANGLE_OPEN;
                  phase_d   = PH_IDLE;
                  elapsed_d = '0;
                end
              end
              default: begin
                phase_d   = PH_IDLE;
                elapsed_d = '0;
              end
            endcase
          end
        end
        REQ_START: begin
          cyc_d     = '0;
          angle_d   = ANGLE_OPEN;
          phase_d   = PH_PREPARE;
          elapsed_d = '0;
        end
        REQ_STOP: begin
          angle_d   = ANGLE_OPEN;
          phase_d   = PH_IDLE;
          elapsed_d = '0;
        end
        REQ_SAMPLE: begin
          if (phase_q == PH_IDLE) begin
            if (sensor_q && (req_if.distance_mm < DIST_W'(near_q))
                && (req_if.distance_mm > DIST_W'(1))) begin
              if (hits_inc >= 2'd2) begin
                hits_d    = '0;
                cyc_d     = '0;
                angle_d   = ANGLE_OPEN;
                phase_d   = PH_PREPARE;
                elapsed_d = '0;
              end else begin
                hits_d = hits_inc;
              end
            end else begin
              hits_d = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_if.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_angle_q <= angle_q;
      res_phase_q <= phase_q;
      res_cyc_q   <= cyc_q;
      res_done_q  <= done_q;
    end
  end

  assign res_if.valid       = res_valid_q;
  assign res_if.servo_angle = res_angle_q;
  assign res_if.phase_code  = res_phase_q;
  assign res_if.cycles_done = res_cyc_q;
  assign res_if.run_done    = res_done_q;

  // Ramp only runs on a squeeze tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SEQ_RAMP) |-> (phase_q == PH_SQUEEZE))
    else $error("ramp busy outside squeeze");

  // Ramp results arrive only when waited for
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ramp_rsp.done |-> (seq_q == SEQ_RAMP))
    else $error("unexpected ramp result");

  // Commanded angle never passes the open position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    angle_q <= ANGLE_OPEN)
    else $error("angle out of range");

  // Run completion is flagged only on entering finish
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && done_d) |=> (phase_q == PH_FINISH))
    else $error("run_done without finish");

endmodule
